/* hw/rtl/shlt_pkg.sv */
// shared types and constants of the service host limit tracker
package shlt_pkg;

  localparam int unsigned HOST_SLOTS = 16;
  localparam int unsigned ID_BITS    = 16;

  localparam int unsigned HOST_ID_W = 16;
  localparam int unsigned ID_W      = (ID_BITS < HOST_ID_W) ? ID_BITS : HOST_ID_W;
  localparam int unsigned SLOT_W    = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
  localparam int unsigned USED_W    = $clog2(HOST_SLOTS + 1);
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned HU_W      = 5;
  localparam int unsigned CMP_W     = (USED_W > HU_W) ? USED_W : HU_W;
  localparam int unsigned TL_W      = 17;
  localparam int unsigned HL_W      = 6;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_CHECK   = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic {
    REG_TOTAL_LIMIT = 1'b0,
    REG_HOST_LIMIT  = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]  host;
    logic [CNT_W-1:0] count;
  } entry_t;

endpackage

/* hw/rtl/shlt_entry_ram.sv */
// host entry memory: one write port, one registered read port
module shlt_entry_ram (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [shlt_pkg::SLOT_W-1:0] rd_addr_i,
  output shlt_pkg::entry_t            rd_data_o,
  input  logic                        wr_en_i,
  input  logic [shlt_pkg::SLOT_W-1:0] wr_addr_i,
  input  shlt_pkg::entry_t            wr_data_i
);
  import shlt_pkg::*;

  entry_t mem_q [HOST_SLOTS];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/service_host_limit_tracker.sv */
// service host limit tracker: admission checks and run counting per host
// a new item is taken only in the idle state, once the previous item is done; each item
//   is held while the host entry memory is scanned one entry per cycle through its
//   single read port, then evaluated and written back
// a finished result waits in the output register while the next item is taken
// reset: limits to -1 (unlimited), run total 0, all entry valid bits cleared at once
module service_host_limit_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     mode_i,
  input  logic [shlt_pkg::HOST_ID_W-1:0] host_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           may_run_o,
  output logic [shlt_pkg::CNT_W-1:0]     total_runs_o,
  output logic [shlt_pkg::HU_W-1:0]      hosts_in_use_o,
  output logic                           table_overflow_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [shlt_pkg::PADDR_W-1:0]   paddr,
  input  logic [shlt_pkg::PDATA_W-1:0]   pwdata,
  output logic [shlt_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import shlt_pkg::*;

  state_e state_q, state_d;

  logic [TL_W-1:0]     total_limit_q;
  logic [HL_W-1:0]     host_limit_q;
  logic [CNT_W-1:0]    run_total_q;
  logic [USED_W-1:0]   used_q;
  logic [HOST_SLOTS-1:0] valid_q;

  logic [1:0]          mode_q;
  logic [ID_W-1:0]     id_q;
  logic [SLOT_W-1:0]   scan_q;
  logic                cmp_vld_q;
  logic [SLOT_W-1:0]   cmp_idx_q;
  logic                hit_q;
  logic [SLOT_W-1:0]   hit_slot_q;
  logic [CNT_W-1:0]    hit_cnt_q;
  logic                free_q;
  logic [SLOT_W-1:0]   free_slot_q;

  logic                out_valid_q;
  logic                may_run_q;
  logic [CNT_W-1:0]    total_runs_q;
  logic [HU_W-1:0]     hosts_in_use_q;
  logic                ovf_q;

  logic                accept;
  logic                proceed;
  logic                rd_en;
  entry_t              rd_data;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  entry_t              wr_data;
  logic                cmp_hit;
  logic                cmp_free;
  logic                cfg_wr;

  logic                may_d;
  logic                ovf_d;
  logic [CNT_W-1:0]    total_d;
  logic [USED_W-1:0]   used_d;
  logic                set_vld;
  logic                clr_vld;
  logic [CNT_W-1:0]    dec_cnt;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign proceed    = !out_valid_q || out_ready_i;
  assign rd_en      = (state_q == ST_SCAN);
  assign cfg_wr     = psel && penable && pwrite && pready;

  assign cmp_hit  = cmp_vld_q && valid_q[cmp_idx_q] && (rd_data.host == id_q);
  assign cmp_free = cmp_vld_q && !valid_q[cmp_idx_q];

  shlt_entry_ram u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_q == SLOT_W'(HOST_SLOTS - 1)) state_d = ST_EVAL;
      end
      ST_EVAL: state_d = ST_UPD;
      ST_UPD: begin
        if (proceed) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    may_d   = 1'b0;
    ovf_d   = 1'b0;
    total_d = run_total_q;
    used_d  = used_q;
    set_vld = 1'b0;
    clr_vld = 1'b0;
    wr_en   = 1'b0;
    wr_addr = hit_slot_q;
    wr_data = '{host: id_q, count: hit_cnt_q};
    dec_cnt = (hit_cnt_q != '0) ? hit_cnt_q - 1'b1 : hit_cnt_q;
    case (mode_q)
      MODE_CHECK: begin
        may_d = 1'b1;
        if (!total_limit_q[TL_W-1] && ({1'b0, run_total_q} >= total_limit_q)) begin
          may_d = 1'b0;
        end else if (!host_limit_q[HL_W-1] && !hit_q &&
                     (CMP_W'(used_q) >= CMP_W'(host_limit_q[HL_W-2:0]))) begin
          may_d = 1'b0;
        end
      end
      MODE_ADD: begin
        if (run_total_q != CNT_MAX) total_d = run_total_q + 1'b1;
        if (hit_q) begin
          wr_en = 1'b1;
          if (hit_cnt_q != CNT_MAX) wr_data.count = hit_cnt_q + 1'b1;
        end else if (free_q) begin
          wr_en         = 1'b1;
          wr_addr       = free_slot_q;
          wr_data.count = CNT_W'(1);
          set_vld       = 1'b1;
          used_d        = used_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (run_total_q != '0) total_d = run_total_q - 1'b1;
        if (hit_q) begin
          wr_en         = 1'b1;
          wr_data.count = dec_cnt;
          if (dec_cnt == '0) begin
            clr_vld = 1'b1;
            used_d  = used_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    wr_en = wr_en && (state_q == ST_UPD) && proceed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      total_limit_q <= '1;
      host_limit_q  <= '1;
      run_total_q   <= '0;
      used_q        <= '0;
      valid_q       <= '0;
      scan_q        <= '0;
      cmp_vld_q     <= 1'b0;
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_TOTAL_LIMIT: total_limit_q <= pwdata[TL_W-1:0];
          REG_HOST_LIMIT:  host_limit_q  <= pwdata[HL_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (state_q == ST_SCAN) scan_q <= scan_q + 1'b1;
      cmp_vld_q <= (state_q == ST_SCAN);
      if (cmp_hit && !hit_q) hit_q <= 1'b1;
      if (cmp_free && !free_q) free_q <= 1'b1;
      if ((state_q == ST_UPD) && proceed) begin
        out_valid_q <= 1'b1;
        run_total_q <= total_d;
        used_q      <= used_d;
        if (set_vld) valid_q[free_slot_q] <= 1'b1;
        if (clr_vld) valid_q[hit_slot_q]  <= 1'b0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      id_q   <= host_id_i[ID_W-1:0];
    end
    cmp_idx_q <= scan_q;
    if (cmp_hit && !hit_q) begin
      hit_slot_q <= cmp_idx_q;
      hit_cnt_q  <= rd_data.count;
    end
    if (cmp_free && !free_q) free_slot_q <= cmp_idx_q;
    if ((state_q == ST_UPD) && proceed) begin
      may_run_q      <= may_d;
      total_runs_q   <= total_d;
      hosts_in_use_q <= HU_W'(used_d);
      ovf_q          <= ovf_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL_LIMIT: prdata = {{(PDATA_W-TL_W){total_limit_q[TL_W-1]}}, total_limit_q};
      REG_HOST_LIMIT:  prdata = {{(PDATA_W-HL_W){host_limit_q[HL_W-1]}}, host_limit_q};
      default:         prdata = '0;
    endcase
  end

  assign pready           = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign may_run_o        = may_run_q;
  assign total_runs_o     = total_runs_q;
  assign hosts_in_use_o   = hosts_in_use_q;
  assign table_overflow_o = ovf_q;

endmodule

/* hw/rtl/shlt_checker.sv */
// port-level checks of the service host limit tracker, bound to the top level
module shlt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           may_run_o,
  input logic [shlt_pkg::CNT_W-1:0]     total_runs_o,
  input logic [shlt_pkg::HU_W-1:0]      hosts_in_use_o,
  input logic                           table_overflow_o
);
  import shlt_pkg::*;

  // a stalled result keeps its valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_runs_o) &&
    $stable(hosts_in_use_o) && $stable(may_run_o) && $stable(table_overflow_o))
    else $error("stalled result changed");

  // an overflow only comes from an add, never with a yes
  a_ovf_no_may: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_overflow_o |-> !may_run_o)
    else $error("overflow together with may_run");

  // occupancy never exceeds the table
  a_hosts_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CMP_W'(hosts_in_use_o) <= CMP_W'(HOST_SLOTS)))
    else $error("hosts_in_use beyond table size");

  // a result needs the full scan, so it never follows an item at once
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too soon after item");

endmodule

bind service_host_limit_tracker shlt_checker u_shlt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .may_run_o        (may_run_o),
  .total_runs_o     (total_runs_o),
  .hosts_in_use_o   (hosts_in_use_o),
  .table_overflow_o (table_overflow_o)
);
